/* design/awbg_pkg.sv */
// Shared types and constants for the white-balance gain calculator.
// No dependencies; imported by awbg_div2, awb_otp_gain_calculator and tb_top.
`timescale 1ns / 1ps

package awbg_pkg;

    localparam int ID_W    = 8;
    localparam int RATIO_W = 10;
    localparam int SCALE_W = 11;    // scaled ratio reaches 1533
    localparam int TYP_W   = 9;
    localparam int GREEN_W = 15;    // green gain from the first divide
    localparam int GAIN_W  = 23;
    localparam int DIV_STEPS = GAIN_W;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN = 23'h000400;
    localparam logic [ID_W-1:0]    ID_ALT_A = 8'h02;
    localparam logic [ID_W-1:0]    ID_ALT_B = 8'h06;
    localparam logic [ID_W-1:0]    ID_ALT_C = 8'h31;
    localparam logic [TYP_W-1:0]   RG_TYP_ALT = 9'h055;
    localparam logic [TYP_W-1:0]   BG_TYP_ALT = 9'h053;
    localparam logic [TYP_W-1:0]   RG_TYP_STD = 9'h102;
    localparam logic [TYP_W-1:0]   BG_TYP_STD = 9'h116;
    localparam logic [RATIO_W:0]   LIGHT_BIAS = 11'd512;

    // Side data that travels with an item through both divide pipelines.
    typedef struct packed {
        logic               zero;
        logic [SCALE_W-1:0] rg;
        logic [SCALE_W-1:0] bg;
        logic [TYP_W-1:0]   rg_typ;
        logic [TYP_W-1:0]   bg_typ;
        logic               r_unity;
        logic               b_unity;
    } awbg_tag_t;

endpackage

/* design/awbg_div2.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on awbg_pkg; used twice by awb_otp_gain_calculator.
`timescale 1ns / 1ps

module awbg_div2 (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  awbg_pkg::awbg_tag_t        in_tag,
    input  logic [awbg_pkg::GAIN_W-1:0]  num_a,
    input  logic [awbg_pkg::SCALE_W-1:0] den_a,
    input  logic [awbg_pkg::GAIN_W-1:0]  num_b,
    input  logic [awbg_pkg::SCALE_W-1:0] den_b,
    output logic                       out_valid,
    output awbg_pkg::awbg_tag_t        out_tag,
    output logic [awbg_pkg::GAIN_W-1:0]  quo_a,
    output logic [awbg_pkg::GAIN_W-1:0]  quo_b
);
    import awbg_pkg::*;

    typedef struct packed {
        logic [SCALE_W-1:0] rem;
        logic [GAIN_W-1:0]  num;   // dividend bits shift out, quotient bits shift in
        logic [SCALE_W-1:0] den;
    } lane_t;

    logic      valid_reg [0:DIV_STEPS];
    awbg_tag_t tag_reg   [0:DIV_STEPS];
    lane_t     a_reg     [0:DIV_STEPS];
    lane_t     b_reg     [0:DIV_STEPS];

    function automatic lane_t div_step(input lane_t x);
        logic [SCALE_W:0] t;
        lane_t            y;
        t = {x.rem, x.num[GAIN_W-1]};
        y.den = x.den;
        if (t >= {1'b0, x.den})
        begin
            t = t - {1'b0, x.den};
            y.num = {x.num[GAIN_W-2:0], 1'b1};
        end
        else
        begin
            y.num = {x.num[GAIN_W-2:0], 1'b0};
        end
        y.rem = t[SCALE_W-1:0];
        return y;
    endfunction

    always_comb
    begin
        valid_reg[0] = in_valid;
        tag_reg[0]   = in_tag;
        a_reg[0]     = '{rem: '0, num: num_a, den: den_a};
        b_reg[0]     = '{rem: '0, num: num_b, den: den_b};
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[i+1] <= tag_reg[i];
            a_reg[i+1]   <= div_step(a_reg[i]);
            b_reg[i+1]   <= div_step(b_reg[i]);
        end
    end

    assign out_valid = valid_reg[DIV_STEPS];
    assign out_tag   = tag_reg[DIV_STEPS];
    assign quo_a     = a_reg[DIV_STEPS].num;
    assign quo_b     = b_reg[DIV_STEPS].num;

endmodule

/* design/awb_otp_gain_calculator.sv */
// Top level of the white-balance gain calculator.
// Depends on awbg_pkg and awbg_div2.
`timescale 1ns / 1ps
//
//  Channel   Signals                                          Handshake
//  input     integrator_id, red_green_ratio, blue_green_ratio, start high, busy low
//            light_red_factor, light_blue_factor
//  result    red_gain, green_gain, blue_gain, gains_valid     done, one cycle
//
// One record is taken every cycle; busy is always low. Each result passes
// through a scaling stage, two 23-stage divide pipelines and the registers
// between them. Reset clears only the pipeline valid bits and done, not
// gains_valid. The receiver cannot stall.

module awb_otp_gain_calculator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [awbg_pkg::ID_W-1:0]     integrator_id,
    input  logic [awbg_pkg::RATIO_W-1:0]  red_green_ratio,
    input  logic [awbg_pkg::RATIO_W-1:0]  blue_green_ratio,
    input  logic [awbg_pkg::RATIO_W-1:0]  light_red_factor,
    input  logic [awbg_pkg::RATIO_W-1:0]  light_blue_factor,
    output logic                          done,
    output logic [awbg_pkg::GAIN_W-1:0]   red_gain,
    output logic [awbg_pkg::GAIN_W-1:0]   green_gain,
    output logic [awbg_pkg::GAIN_W-1:0]   blue_gain,
    output logic                          gains_valid
);
    import awbg_pkg::*;

    localparam int PROD_W = RATIO_W + RATIO_W + 1;

    // Stage 1: scaled ratios and typical pair.
    logic      s1_valid_reg, s1_valid_next;
    awbg_tag_t s1_tag_reg, s1_tag_next;
    logic [PROD_W-1:0] rg_prod, bg_prod;
    logic alt_id;

    assign busy = 1'b0;

    always_comb
    begin
        rg_prod = PROD_W'(red_green_ratio) * PROD_W'(light_red_factor + LIGHT_BIAS);
        bg_prod = PROD_W'(blue_green_ratio) * PROD_W'(light_blue_factor + LIGHT_BIAS);
        alt_id  = (integrator_id == ID_ALT_A) || (integrator_id == ID_ALT_B)
                  || (integrator_id == ID_ALT_C);
        s1_valid_next = start && !busy;
        s1_tag_next.rg = (light_red_factor == '0) ? SCALE_W'(red_green_ratio)
                                                 : rg_prod[PROD_W-1:RATIO_W];
        s1_tag_next.bg = (light_blue_factor == '0) ? SCALE_W'(blue_green_ratio)
                                                  : bg_prod[PROD_W-1:RATIO_W];
        s1_tag_next.zero    = (s1_tag_next.rg == '0) || (s1_tag_next.bg == '0);
        s1_tag_next.rg_typ  = alt_id ? RG_TYP_ALT : RG_TYP_STD;
        s1_tag_next.bg_typ  = alt_id ? BG_TYP_ALT : BG_TYP_STD;
        s1_tag_next.r_unity = 1'b0;
        s1_tag_next.b_unity = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= s1_tag_next;
    end

    // First divide: green candidates from red and from blue.
    logic      d1_valid;
    awbg_tag_t d1_tag;
    logic [GAIN_W-1:0] g_from_r, g_from_b;

    awbg_div2 u_div_green (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_tag    (s1_tag_reg),
        .num_a     (GAIN_W'({s1_tag_reg.rg, 10'b0})),
        .den_a     (SCALE_W'(s1_tag_reg.rg_typ)),
        .num_b     (GAIN_W'({s1_tag_reg.bg, 10'b0})),
        .den_b     (SCALE_W'(s1_tag_reg.bg_typ)),
        .out_valid (d1_valid),
        .out_tag   (d1_tag),
        .quo_a     (g_from_r),
        .quo_b     (g_from_b)
    );

    // Middle stage: pick the unity channel and form the second dividends.
    logic      s2_valid_reg;
    awbg_tag_t s2_tag_reg, s2_tag_next;
    logic [GAIN_W-1:0] s2_rnum_reg, s2_rnum_next, s2_bnum_reg, s2_bnum_next;
    logic [GREEN_W-1:0] green;
    logic b_low, r_low;

    always_comb
    begin
        b_low = d1_tag.bg < SCALE_W'(d1_tag.bg_typ);
        r_low = d1_tag.rg < SCALE_W'(d1_tag.rg_typ);
        s2_tag_next = d1_tag;
        if (b_low && r_low)
        begin
            green = GREEN_W'(UNITY_GAIN);
        end
        else if (b_low || (!r_low && !(g_from_b > g_from_r)))
        begin
            s2_tag_next.r_unity = 1'b1;
            green = g_from_r[GREEN_W-1:0];
        end
        else
        begin
            s2_tag_next.b_unity = 1'b1;
            green = g_from_b[GREEN_W-1:0];
        end
        s2_rnum_next = GAIN_W'(green) * GAIN_W'(d1_tag.rg_typ);
        s2_bnum_next = GAIN_W'(green) * GAIN_W'(d1_tag.bg_typ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= d1_valid;
        end
    end

    logic [GREEN_W-1:0] s2_green_reg;

    always_ff @(posedge clk)
    begin
        s2_tag_reg   <= s2_tag_next;
        s2_rnum_reg  <= s2_rnum_next;
        s2_bnum_reg  <= s2_bnum_next;
        s2_green_reg <= green;
    end

    // Second divide: red and blue gains. Green rides along in a delay line.
    logic      d2_valid;
    awbg_tag_t d2_tag;
    logic [GAIN_W-1:0] r_quo, b_quo;
    logic [GREEN_W-1:0] green_dly_reg [0:DIV_STEPS-1];

    awbg_div2 u_div_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_tag    (s2_tag_reg),
        .num_a     (s2_rnum_reg),
        .den_a     (s2_tag_reg.rg),
        .num_b     (s2_bnum_reg),
        .den_b     (s2_tag_reg.bg),
        .out_valid (d2_valid),
        .out_tag   (d2_tag),
        .quo_a     (r_quo),
        .quo_b     (b_quo)
    );

    always_ff @(posedge clk)
    begin
        green_dly_reg[0] <= s2_green_reg;
        for (int i = 1; i < DIV_STEPS; i++)
        begin
            green_dly_reg[i] <= green_dly_reg[i-1];
        end
    end

    // Output register.
    logic done_reg;
    logic [GAIN_W-1:0] red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic valid_reg, valid_next;

    always_comb
    begin
        red_next   = d2_tag.r_unity ? UNITY_GAIN : r_quo;
        blue_next  = d2_tag.b_unity ? UNITY_GAIN : b_quo;
        green_next = GAIN_W'(green_dly_reg[DIV_STEPS-1]);
        valid_next = !d2_tag.zero;
        if (d2_tag.zero)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        valid_reg <= valid_next;
    end

    assign done        = done_reg;
    assign red_gain    = red_reg;
    assign green_gain  = green_reg;
    assign blue_gain   = blue_reg;
    assign gains_valid = valid_reg;

    // A flagged result carries no gains.
    a_zero_gains: assert property (@(posedge clk) disable iff (!rst_n)
        done && !gains_valid |-> red_gain == '0 && green_gain == '0 && blue_gain == '0)
        else $error("invalid result carries nonzero gains");

    // A computed result gives unity to at least one channel.
    a_unity: assert property (@(posedge clk) disable iff (!rst_n)
        done && gains_valid |->
            red_gain == UNITY_GAIN || green_gain == UNITY_GAIN || blue_gain == UNITY_GAIN)
        else $error("no channel at unity gain");

endmodule

/* verif/tb_top.sv */
// Testbench for the white-balance gain calculator: directed and random records,
// checked against a behavioral gain predictor. Depends on awbg_pkg and the RTL.
`timescale 1ns / 1ps

class gain_scoreboard;
    typedef struct {
        logic [awbg_pkg::GAIN_W-1:0] r, g, b;
        logic                        ok;
    } gains_t;

    gains_t pending[$];
    int     errors;
    int     matched;

    // Predicts the gains for one record and queues them.
    function void note_record(logic [7:0] id, logic [9:0] rg_in, logic [9:0] bg_in,
                              logic [9:0] lr, logic [9:0] lb);
        gains_t      e;
        logic [31:0] rg, bg, rt, bt, gr, gb;
        rg = (lr == 0) ? 32'(rg_in) : (32'(rg_in) * (32'(lr) + 32'd512)) / 32'd1024;
        bg = (lb == 0) ? 32'(bg_in) : (32'(bg_in) * (32'(lb) + 32'd512)) / 32'd1024;
        if (id == awbg_pkg::ID_ALT_A || id == awbg_pkg::ID_ALT_B
            || id == awbg_pkg::ID_ALT_C)
        begin
            rt = 32'(awbg_pkg::RG_TYP_ALT);
            bt = 32'(awbg_pkg::BG_TYP_ALT);
        end
        else
        begin
            rt = 32'(awbg_pkg::RG_TYP_STD);
            bt = 32'(awbg_pkg::BG_TYP_STD);
        end
        e.ok = !(rg == 0 || bg == 0);
        e.r = '0; e.g = '0; e.b = '0;
        if (e.ok)
        begin
            gr = 32'd1024 * rg / rt;
            gb = 32'd1024 * bg / bt;
            if (bg < bt && rg < rt)
            begin
                e.g = awbg_pkg::UNITY_GAIN;
                e.b = 23'(32'd1024 * bt / bg);
                e.r = 23'(32'd1024 * rt / rg);
            end
            else if (bg < bt || (rg >= rt && gb <= gr))
            begin
                e.r = awbg_pkg::UNITY_GAIN; e.g = 23'(gr); e.b = 23'(gr * bt / bg);
            end
            else
            begin
                e.b = awbg_pkg::UNITY_GAIN; e.g = 23'(gb); e.r = 23'(gb * rt / rg);
            end
        end
        pending.push_back(e);
    endfunction

    function void check_result(logic [22:0] r, logic [22:0] g, logic [22:0] b,
                               logic ok);
        gains_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result r=%h g=%h b=%h valid=%b", $time, r, g, b, ok);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e.r !== r || e.g !== g || e.b !== b || e.ok !== ok)
        begin
            $display("%0t: mismatch expected r=%h g=%h b=%h valid=%b", $time,
                     e.r, e.g, e.b, e.ok);
            $display("%0t:          actual   r=%h g=%h b=%h valid=%b", $time, r, g, b, ok);
            errors++;
        end
        else
            matched++;
    endfunction
endclass

module tb_top;
    import awbg_pkg::*;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              start = 0;
    logic              busy;
    logic [ID_W-1:0]   integrator_id = 0;
    logic [9:0]        red_green_ratio = 0, blue_green_ratio = 0;
    logic [9:0]        light_red_factor = 0, light_blue_factor = 0;
    logic              done;
    logic [GAIN_W-1:0] red_gain, green_gain, blue_gain;
    logic              gains_valid;

    gain_scoreboard sb = new();
    int             cycles = 0;
    int             sent = 0;

    awb_otp_gain_calculator dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && done)
            sb.check_result(red_gain, green_gain, blue_gain, gains_valid);
        if (cycles > 200000)
        begin
            $display("** awb_otp_gain_calculator: FAILED **");
            $finish;
        end
    end

    // Presents one record and holds it until the transfer; start stays high after.
    task send_record(logic [7:0] id, logic [9:0] rg, logic [9:0] bg, logic [9:0] lr,
                     logic [9:0] lb);
        start <= 1;
        integrator_id <= id;
        red_green_ratio <= rg;
        blue_green_ratio <= bg;
        light_red_factor <= lr;
        light_blue_factor <= lb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_record(id, rg, bg, lr, lb);
        sent++;
    endtask

    task idle_burst();
        start <= 0;
        repeat ($urandom_range(1, 13))
            @(posedge clk);
    endtask

    function logic [7:0] pick_id();
        case ($urandom_range(0, 4))
            0: return ID_ALT_A;
            1: return ID_ALT_B;
            2: return ID_ALT_C;
            default: return 8'($urandom);
        endcase
    endfunction

    function logic [9:0] pick_ratio();
        case ($urandom_range(0, 5))
            0: return 10'($urandom_range(0, 3));
            1: return 10'($urandom_range(1020, 1023));
            2: return 10'($urandom_range('h50, 'h118));
            default: return 10'($urandom);
        endcase
    endfunction

    function logic [9:0] pick_light();
        case ($urandom_range(0, 3))
            0: return 10'd0;
            1: return 10'($urandom_range(0, 2));
            default: return 10'($urandom);
        endcase
    endfunction

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Zero ratios, zero after scaling, both extremes, all four gain branches,
        // the tie between green candidates, and every alternate id.
        send_record(8'h00, 10'd0, 10'd300, 10'd0, 10'd0);
        send_record(8'h00, 10'd300, 10'd0, 10'd0, 10'd0);
        send_record(8'h00, 10'd1, 10'd300, 10'd1, 10'd0);
        send_record(8'h00, 10'd300, 10'd1, 10'd0, 10'd1);
        send_record(8'hFF, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_record(8'hFF, 10'd1, 10'd1, 10'd0, 10'd0);
        send_record(ID_ALT_A, 10'd1, 10'd1, 10'd0, 10'd0);
        send_record(ID_ALT_B, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_record(ID_ALT_C, 10'h55, 10'h53, 10'd0, 10'd0);
        send_record(8'h00, 10'h102, 10'h116, 10'd0, 10'd0);
        send_record(8'h00, 10'h80, 10'h80, 10'd0, 10'd0);
        send_record(8'h00, 10'h200, 10'h80, 10'd0, 10'd0);
        send_record(8'h00, 10'h80, 10'h200, 10'd0, 10'd0);
        send_record(8'h00, 10'h204, 10'h22C, 10'd0, 10'd0);
        send_record(8'h00, 10'h300, 10'h22C, 10'd0, 10'd0);
        send_record(8'h00, 10'h204, 10'h300, 10'd0, 10'd0);
        send_record(8'h00, 10'h155, 10'h2AA, 10'd512, 10'd512);
        send_record(8'h31, 10'd2, 10'd2, 10'd1, 10'd1);

        for (int i = 0; i < 1800; i++)
        begin
            if (i < 1500 && $urandom_range(0, 9) == 0)
                idle_burst();
            send_record(pick_id(), pick_ratio(), pick_ratio(), pick_light(),
                        pick_light());
        end
        start <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);

        $display("Sent %0d calibration records, %0d gain results matched.", sent,
                 sb.matched);
        if (sb.errors == 0)
            $display("** awb_otp_gain_calculator: PASSED **");
        else
            $display("** awb_otp_gain_calculator: FAILED **");
        $finish;
    end
endmodule
